[rtl/tmqrs_pkg.sv]
package tmqrs_pkg;

    localparam int NUM_QUEUES     = 16;
    localparam int GROUP_DEPTH    = 16;
    localparam int MAX_SLOTS      = 8;
    localparam int RESULT_CAP     = 16;
    localparam int RELEASES_RESET = 10;

    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int GW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = $clog2(GROUP_DEPTH + 1);
    localparam int SZW = $clog2(MAX_SLOTS + 1);
    localparam int NW  = $clog2(RESULT_CAP + 1);
    localparam int CFGW = 5;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ENQ   = 3'd1;
    localparam logic [2:0] OP_REG   = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_UNREG = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [1:0] ST_REL  = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_SCAN_RD, S_SCAN_EV, S_SRCH, S_SRCH_END,
        S_POP_G, S_POP_S0, S_POP_S1, S_POP_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]    next_time;
        logic [SW-1:0]  cur;
        logic [SZW-1:0] size;
    } t_group;

    typedef struct packed {
        logic          load_in;
        logic          op_exec;
        logic          scan_rd;
        logic          scan_ev;
        logic          srch_clr;
        logic          srch_step;
        logic          pop_s0;
        logic          pop_s1;
        logic          pop_fin;
        logic          sel_best;
        logic [QW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       found;
    } t_stat;

endpackage

[rtl/tmqrs_ram.sv]
module tmqrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/tmqrs_dp.sv]
module tmqrs_dp
    import tmqrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_queue_index,
    input  logic [2:0]  i_slot_index,
    input  logic [31:0] i_time_value,
    input  logic [3:0]  i_group_size,
    input  logic        i_stamp_flag,
    input  logic [31:0] i_now_ms,
    output logic [1:0]  o_status,
    output logic [3:0]  o_out_queue,
    output logic [2:0]  o_out_slot,
    output logic        o_needs_stamp
);
    localparam int NSL = NUM_QUEUES * MAX_SLOTS;

    logic [2:0]  r_op;
    logic [3:0]  r_q;
    logic [2:0]  r_slot;
    logic [31:0] r_tv;
    logic [3:0]  r_gs;
    logic        r_stamp;
    logic [31:0] r_now;

    logic                r_active [NUM_QUEUES];
    logic [GW-1:0]       r_head   [NUM_QUEUES];
    logic [CW-1:0]       r_count  [NUM_QUEUES];
    logic [31:0]         r_iv     [NUM_QUEUES];
    logic [31:0]         r_lr     [NUM_QUEUES];
    logic [NSL-1:0]      r_svld;
    logic [NUM_QUEUES-1:0] r_ready;
    logic                r_found;
    logic [QW-1:0]       r_best;
    logic [31:0]         r_best_iv;
    t_group              r_g;
    logic                r_vld_q;
    logic                r_ns;

    logic [1:0]  r_o_status;
    logic [3:0]  r_o_queue;
    logic [2:0]  r_o_slot;
    logic        r_o_ns;

    logic [QW-1:0]  w_sel;
    logic [GW-1:0]  w_head;
    logic [CW-1:0]  w_cnt;
    logic [31:0]    w_iv;
    logic [31:0]    w_lr;
    logic           w_q_ok;
    logic           w_known;
    logic           w_slot_ok;
    logic           w_full;
    logic [SZW-1:0] w_gsz;
    logic [SZW-1:0] w_cur1;
    logic           w_requeue;
    logic [31:0]    w_delay;
    logic           w_g_we;
    t_group         w_g_wdata;
    t_group         w_grd;
    logic [QW+SW-1:0] w_sraddr;
    logic [32:0]    w_srd;
    logic           w_s_we;

    assign w_sel = i_cmd.sel_best ? r_best :
                   (i_cmd.scan_rd || i_cmd.scan_ev || i_cmd.srch_step) ? i_cmd.idx :
                   r_q[QW-1:0];
    assign w_head = r_head[w_sel];
    assign w_cnt  = r_count[w_sel];
    assign w_iv   = r_iv[w_sel];
    assign w_lr   = r_lr[w_sel];

    assign w_q_ok    = 32'(r_q) < NUM_QUEUES;
    assign w_known   = w_q_ok && r_active[w_sel];
    assign w_slot_ok = 32'(r_slot) < MAX_SLOTS;
    assign w_full    = w_cnt >= CW'(GROUP_DEPTH);

    // group size clamp to one..max slots
    always_comb begin
        if (r_gs == 4'd0) begin
            w_gsz = SZW'(1);
        end else if (32'(r_gs) > MAX_SLOTS) begin
            w_gsz = SZW'(MAX_SLOTS);
        end else begin
            w_gsz = SZW'(r_gs);
        end
    end

    assign w_cur1    = SZW'(r_g.cur) + SZW'(1);
    assign w_requeue = w_cur1 < r_g.size;
    assign w_delay   = r_vld_q ? w_srd[31:0] : 32'd0;

    assign w_g_we = (i_cmd.op_exec && r_op == OP_ENQ && w_known && !w_full)
                 || (i_cmd.pop_fin && w_requeue);
    always_comb begin
        if (i_cmd.op_exec) begin
            w_g_wdata = '{next_time: r_tv, cur: '0, size: w_gsz};
        end else begin
            w_g_wdata = '{next_time: r_now + w_delay, cur: w_cur1[SW-1:0], size: r_g.size};
        end
    end

    // tail slot sits at head plus count, modulo the fifo depth
    tmqrs_ram #(
        .WIDTH ($bits(t_group)),
        .DEPTH (NUM_QUEUES * GROUP_DEPTH)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr ({w_sel, GW'(w_head + w_cnt[GW-1:0])}),
        .i_wdata (w_g_wdata),
        .i_raddr ({w_sel, w_head}),
        .o_rdata (w_grd)
    );

    assign w_sraddr = i_cmd.pop_s0 ? {w_sel, w_grd.cur} : {w_sel, w_cur1[SW-1:0]};
    assign w_s_we   = i_cmd.op_exec && r_op == OP_SET && w_known && w_slot_ok;

    tmqrs_ram #(
        .WIDTH (33),
        .DEPTH (NSL)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr ({w_sel, r_slot[SW-1:0]}),
        .i_wdata ({r_stamp, r_tv}),
        .i_raddr (w_sraddr),
        .o_rdata (w_srd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_operation;
            r_q     <= i_queue_index;
            r_slot  <= i_slot_index;
            r_tv    <= i_time_value;
            r_gs    <= i_group_size;
            r_stamp <= i_stamp_flag;
            r_now   <= i_now_ms;
        end
        r_vld_q <= r_svld[w_sraddr];
        if (i_cmd.pop_s0) begin
            r_g <= w_grd;
        end
        if (i_cmd.pop_s1) begin
            r_ns <= r_vld_q && w_srd[32];
        end
        if (i_cmd.srch_step && r_ready[w_sel] && (!r_found || w_iv < r_best_iv)) begin
            r_best    <= w_sel;
            r_best_iv <= w_iv;
        end
        if (i_cmd.op_exec) begin
            r_o_slot <= '0;
            r_o_ns   <= 1'b0;
            r_o_queue <= (r_op == OP_CLEAR) ? 4'd0 : r_q;
            unique case (r_op)
                OP_ENQ:            r_o_status <= !w_known ? ST_UNK :
                                                 (w_full ? ST_FULL : ST_ACC);
                OP_REG:            r_o_status <= w_q_ok ? ST_ACC : ST_UNK;
                OP_SET, OP_UNREG:  r_o_status <= w_known ? ST_ACC : ST_UNK;
                default:           r_o_status <= ST_ACC;
            endcase
            if (r_op == OP_REG && w_q_ok) begin
                r_iv[w_sel] <= r_tv;
                r_lr[w_sel] <= r_now;
            end
        end
        if (i_cmd.pop_fin) begin
            r_o_status <= ST_REL;
            r_o_queue  <= 4'(r_best);
            r_o_slot   <= 3'(r_g.cur);
            r_o_ns     <= r_ns;
            if (!w_requeue) begin
                r_lr[w_sel] <= r_now;
            end
        end

        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_active[i] <= 1'b0;
                r_head[i]   <= '0;
                r_count[i]  <= '0;
            end
            r_svld  <= '0;
            r_ready <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.op_exec) begin
                case (r_op)
                    OP_ENQ: begin
                        if (w_known && !w_full) begin
                            r_count[w_sel] <= w_cnt + CW'(1);
                        end
                    end
                    OP_REG: begin
                        if (w_q_ok) begin
                            if (!r_active[w_sel]) begin
                                r_head[w_sel]  <= '0;
                                r_count[w_sel] <= '0;
                            end
                            r_active[w_sel] <= 1'b1;
                            r_svld[w_sel*MAX_SLOTS +: MAX_SLOTS] <= '0;
                        end
                    end
                    OP_SET: begin
                        if (w_known && w_slot_ok) begin
                            r_svld[{w_sel, r_slot[SW-1:0]}] <= 1'b1;
                        end
                    end
                    OP_UNREG: begin
                        if (w_known) begin
                            r_active[w_sel] <= 1'b0;
                            r_head[w_sel]   <= '0;
                            r_count[w_sel]  <= '0;
                        end
                    end
                    OP_CLEAR: begin
                        for (int i = 0; i < NUM_QUEUES; i++) begin
                            r_active[i] <= 1'b0;
                            r_head[i]   <= '0;
                            r_count[i]  <= '0;
                        end
                        r_svld <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan_ev) begin
                r_ready[w_sel] <= r_active[w_sel] && w_cnt != '0
                    && r_now >= w_grd.next_time
                    && !(w_grd.cur == '0 && (r_now - w_lr) < w_iv);
            end
            if (i_cmd.srch_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.srch_step && r_ready[w_sel]) begin
                r_found <= 1'b1;
            end
            if (i_cmd.pop_fin) begin
                r_ready[w_sel] <= 1'b0;
                r_head[w_sel]  <= GW'(w_head + GW'(1));
                if (!w_requeue) begin
                    r_count[w_sel] <= w_cnt - CW'(1);
                end
            end
        end
    end

    assign o_stat.op    = r_op;
    assign o_stat.found = r_found;

    assign o_status      = r_o_status;
    assign o_out_queue   = r_o_queue;
    assign o_out_slot    = r_o_slot;
    assign o_needs_stamp = r_o_ns;
endmodule

[rtl/tmqrs_ctrl.sv]
module tmqrs_ctrl
    import tmqrs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_last,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CFGW-1:0] i_cfg_data,
    output t_cmd            o_cmd,
    input  t_stat           i_stat
);
    localparam logic [QW-1:0] QMAX = QW'(NUM_QUEUES - 1);

    t_state          r_state, n_state;
    logic [QW-1:0]   r_cnt;
    logic [NW-1:0]   r_n;
    logic            r_pend;
    logic            r_more;
    logic            r_out_valid;
    logic            r_last;
    logic [CFGW-1:0] r_rel;

    logic            w_in_acc;
    logic            w_out_acc;
    logic [NW-1:0]   w_limit;
    logic            w_more;
    logic            w_op_ok;

    assign w_in_acc  = i_in_valid && r_state == S_IDLE;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_op_ok   = i_stat.op == OP_ENQ || i_stat.op == OP_REG || i_stat.op == OP_SET
                    || i_stat.op == OP_UNREG || i_stat.op == OP_CLEAR;

    // zero allows one release, anything above the cap allows the cap
    always_comb begin
        if (r_rel == '0) begin
            w_limit = NW'(1);
        end else if (32'(r_rel) > RESULT_CAP) begin
            w_limit = NW'(RESULT_CAP);
        end else begin
            w_limit = NW'(r_rel);
        end
    end
    assign w_more = i_stat.found && r_n < w_limit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_in_acc) n_state = S_OP;
            S_OP: begin
                if (i_stat.op == OP_TICK) begin
                    n_state = S_SCAN_RD;
                end else if (w_op_ok) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_EV;
            S_SCAN_EV:  n_state = (r_cnt == QMAX) ? S_SRCH : S_SCAN_RD;
            S_SRCH:     if (r_cnt == QMAX) n_state = S_SRCH_END;
            S_SRCH_END: begin
                if (r_pend) begin
                    n_state = S_OUT;
                end else if (w_more) begin
                    n_state = S_POP_G;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POP_G:    n_state = S_POP_S0;
            S_POP_S0:   n_state = S_POP_S1;
            S_POP_S1:   n_state = S_POP_FIN;
            S_POP_FIN:  n_state = S_SRCH;
            S_OUT:      if (w_out_acc) n_state = r_more ? S_POP_G : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = w_in_acc;
        o_cmd.idx       = r_cnt;
        unique case (r_state)
            S_OP:       o_cmd.op_exec   = 1'b1;
            S_SCAN_RD:  o_cmd.scan_rd   = 1'b1;
            S_SCAN_EV: begin
                o_cmd.scan_ev  = 1'b1;
                o_cmd.srch_clr = 1'b1;
            end
            S_SRCH:     o_cmd.srch_step = 1'b1;
            S_POP_G:    o_cmd.sel_best  = 1'b1;
            S_POP_S0: begin
                o_cmd.sel_best = 1'b1;
                o_cmd.pop_s0   = 1'b1;
            end
            S_POP_S1: begin
                o_cmd.sel_best = 1'b1;
                o_cmd.pop_s1   = 1'b1;
            end
            S_POP_FIN: begin
                o_cmd.sel_best = 1'b1;
                o_cmd.pop_fin  = 1'b1;
                o_cmd.srch_clr = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_n         <= '0;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_rel       <= CFGW'(RELEASES_RESET);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_rel <= i_cfg_data;
            end
            if (r_state == S_SCAN_EV || r_state == S_SRCH) begin
                r_cnt <= (r_cnt == QMAX) ? '0 : r_cnt + QW'(1);
            end
            if (r_state == S_OP) begin
                r_cnt  <= '0;
                r_n    <= '0;
                r_pend <= 1'b0;
                r_more <= 1'b0;
                if (i_stat.op != OP_TICK && w_op_ok) begin
                    r_out_valid <= 1'b1;
                    r_last      <= 1'b1;
                end
            end
            if (r_state == S_POP_FIN) begin
                r_n    <= r_n + NW'(1);
                r_pend <= 1'b1;
            end
            // a held release goes out once we know whether another follows
            if (r_state == S_SRCH_END && r_pend) begin
                r_out_valid <= 1'b1;
                r_last      <= !w_more;
                r_more      <= w_more;
            end
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
                r_pend      <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_last      = r_last;
    assign o_cfg_ready = 1'b1;

    a_release_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_OP) |-> r_n <= w_limit)
        else $error("more releases than the per-tick limit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_last) |=> r_state == S_IDLE)
        else $error("work continued after the final word");

    a_no_input_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input taken while a result word waits");

    a_pop_after_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_G) |-> $past(i_stat.found))
        else $error("pop started without a selected queue");
endmodule

[rtl/timed_multi_queue_release_scheduler_top.sv]
// Release scheduler for sixteen queues of multi-slot groups. Control operations
// (enqueue, register, set slot, unregister, clear all) each give one result word,
// which then waits on the output side. A tick first evaluates the readiness of
// every queue, then for each released slot runs the one-queue-per-cycle
// shortest-interval search and the group and slot memory reads. The release limit
// register is to be written over the cfg port only while the block is idle; the
// block itself does not enforce this.
module timed_multi_queue_release_scheduler_top
    import tmqrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_queue_index,
    input  logic [2:0]  i_slot_index,
    input  logic [31:0] i_time_value,
    input  logic [3:0]  i_group_size,
    input  logic        i_stamp_flag,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_out_queue,
    output logic [2:0]  o_out_slot,
    output logic        o_needs_stamp,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    tmqrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    tmqrs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_operation),
        .i_queue_index (i_queue_index),
        .i_slot_index  (i_slot_index),
        .i_time_value  (i_time_value),
        .i_group_size  (i_group_size),
        .i_stamp_flag  (i_stamp_flag),
        .i_now_ms      (i_now_ms),
        .o_status      (o_status),
        .o_out_queue   (o_out_queue),
        .o_out_slot    (o_out_slot),
        .o_needs_stamp (o_needs_stamp)
    );
endmodule
